### hw/rtl/sbc_pkg.sv
// Shared types, constants and round functions for the SHA-256 block compressor.
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned INDEX_W     = 3;
    localparam int unsigned TDATA_W     = 40;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MSG  = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // One queued input beat, already unpacked.
    typedef struct packed {
        logic                req_type;
        logic [INDEX_W-1:0]  word_index;
        word_t               data;
        logic                last_block;
    } item_t;

    function automatic word_t initial_hash(input logic [INDEX_W-1:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        word_t v;
        case (t)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### hw/rtl/sbc_front.sv
// Input side: takes stream beats, unpacks them and queues them for the engine.
`timescale 1ns / 1ps

module sbc_front #(
    parameter int unsigned DEPTH = sbc_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbc_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    output logic                         q_valid,
    input  logic                         q_pop,
    output sbc_pkg::item_t               q_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sbc_pkg::item_t    entries_reg [DEPTH];
    sbc_pkg::item_t    in_item;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_item.req_type   = s_tuser;
    assign in_item.word_index = s_tdata[sbc_pkg::INDEX_W-1:0];
    assign in_item.data       = s_tdata[sbc_pkg::INDEX_W +: sbc_pkg::WORD_W];
    assign in_item.last_block = s_tlast;

    assign s_tready = (count_reg != CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entries_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### hw/rtl/sbc_back.sv
// Engine: chaining words, message window, 64-round compression and digest output.
`timescale 1ns / 1ps

module sbc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  sbc_pkg::item_t               q_item,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sbc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                         m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_FINAL = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam int unsigned NW = 8;
    localparam int unsigned NM = 16;
    localparam int unsigned IW = sbc_pkg::INDEX_W;

    state_t              state_reg, state_next;
    logic [5:0]          round_reg, round_next;
    logic [3:0]          wc_reg, wc_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       emit_idx_reg, emit_idx_next;
    sbc_pkg::word_t      chain_reg [NW];
    sbc_pkg::word_t      chain_next [NW];
    sbc_pkg::word_t      var_reg [NW];
    sbc_pkg::word_t      var_next [NW];
    sbc_pkg::word_t      w_reg [NM];
    sbc_pkg::word_t      w_next [NM];
    logic                m_valid_reg, m_valid_next;
    sbc_pkg::word_t      m_word_reg, m_word_next;
    logic [IW-1:0]       m_index_reg, m_index_next;
    logic                m_last_reg, m_last_next;
    sbc_pkg::word_t      t1, t2, w_new, ch, maj;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(sbc_pkg::TDATA_W - sbc_pkg::WORD_W - IW){1'b0}},
                       m_index_reg, m_word_reg};

    assign q_pop = q_valid && (state_reg == ST_IDLE);

    // one SHA-256 round on the working set, and the next schedule word
    always_comb begin
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t1    = var_reg[7] + sbc_pkg::big_sigma1(var_reg[4]) + ch
              + sbc_pkg::round_k(round_reg) + w_reg[0];
        t2    = sbc_pkg::big_sigma0(var_reg[0]) + maj;
        w_new = w_reg[0] + sbc_pkg::small_sigma0(w_reg[1]) + w_reg[9]
              + sbc_pkg::small_sigma1(w_reg[14]);
    end

    always_comb begin
        state_next    = state_reg;
        round_next    = round_reg;
        wc_next       = wc_reg;
        pend_next     = pend_reg;
        emit_idx_next = emit_idx_reg;
        chain_next    = chain_reg;
        var_next      = var_reg;
        w_next        = w_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_word_next   = m_word_reg;
        m_index_next  = m_index_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.req_type == sbc_pkg::REQ_LOAD) begin
                        chain_next[q_item.word_index] = q_item.data;
                    end else begin
                        for (int i = 0; i < NM - 1; i++) begin
                            w_next[i] = w_reg[i+1];
                        end
                        w_next[NM-1] = q_item.data;
                        pend_next    = pend_reg | q_item.last_block;
                        wc_next      = wc_reg + 1'b1;
                        if (wc_reg == 4'd15) begin
                            var_next   = chain_reg;
                            round_next = '0;
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN: begin
                var_next[0] = t1 + t2;
                var_next[1] = var_reg[0];
                var_next[2] = var_reg[1];
                var_next[3] = var_reg[2];
                var_next[4] = var_reg[3] + t1;
                var_next[5] = var_reg[4];
                var_next[6] = var_reg[5];
                var_next[7] = var_reg[6];
                for (int i = 0; i < NM - 1; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[NM-1] = w_new;
                round_next   = round_reg + 1'b1;
                if (round_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < NW; i++) begin
                    chain_next[i] = chain_reg[i] + var_reg[i];
                end
                pend_next     = 1'b0;
                emit_idx_next = '0;
                state_next    = pend_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = chain_reg[emit_idx_reg];
                    m_index_next  = emit_idx_reg;
                    m_last_next   = (emit_idx_reg == IW'(NW - 1));
                    emit_idx_next = emit_idx_reg + 1'b1;
                    if (emit_idx_reg == IW'(NW - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            wc_reg       <= '0;
            pend_reg     <= 1'b0;
            emit_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NW; i++) begin
                chain_reg[i] <= sbc_pkg::initial_hash(IW'(i));
            end
        end else begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            wc_reg       <= wc_next;
            pend_reg     <= pend_next;
            emit_idx_reg <= emit_idx_next;
            m_valid_reg  <= m_valid_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        var_reg     <= var_next;
        w_reg       <= w_next;
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // round counter only moves while compressing
    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_RUN) |-> (round_reg == '0))
        else $error("round counter not zero outside compression");

    // a complete block has been taken in whenever the rounds run
    a_block_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (wc_reg == '0))
        else $error("compression running on a partial block");

    // queue is only drained between blocks
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !q_pop)
        else $error("queue popped while engine busy");

    // tlast marks word h only
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_index_reg == IW'(NW - 1))))
        else $error("tlast not on word h");

    // a digest run leaves the engine only after word h is loaded
    a_emit_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(state_reg == ST_EMIT) |-> (m_valid_reg && m_last_reg))
        else $error("digest run ended early");

endmodule

### hw/rtl/sha256_block_compress_top.sv
// Top level of the SHA-256 block compressor: input queue plus compression engine.
`timescale 1ns / 1ps

// Flow: load beats and message beats leave the queue one at a time while the engine is
// idle; the sixteenth word of a block starts the 64 rounds (one round per cycle), after
// which the result is folded into the chaining value, and a block marked last then holds
// the engine while its eight digest words go out. The engine takes no new beat until the
// block is folded and any digest sent. Digest beats are registered and follow the fold,
// one beat per cycle while m_tready is high. Up to four input beats queue meanwhile.
// Reset (aresetn low, synchronous) empties the queue and restores the SHA-256 IV.

module sha256_block_compress_top #(
    parameter int unsigned QUEUE_DEPTH = sbc_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sbc_pkg::TDATA_W-1:0]  s_tdata,   // [2:0] word_index, [34:3] data
    input  logic                         s_tuser,   // req_type: 0 load, 1 message
    input  logic                         s_tlast,   // last_block
    // digest stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sbc_pkg::TDATA_W-1:0]  m_tdata,   // [31:0] hash_word, [34:32] hash_index
    output logic                         m_tlast    // set on word h
);

    logic            q_valid;
    logic            q_pop;
    sbc_pkg::item_t  q_item;

    // front: takes beats at full rate into a short queue while the queue is not full
    sbc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // back: chaining state, rounds and registered digest output
    sbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
